[rtl/core/jnq_pkg.sv]
// jnq_pkg: item types, register map, action codes and deflection helpers
// for the joystick navigation qualifier. No dependencies.
`timescale 1ns / 1ps

package jnq_pkg;

    // Number of settled polls before the center starts to track the stick
    localparam int unsigned SETTLE_POLLS = 32;
    // Invalid polls in a row tolerated before the stick counts as gone
    localparam int unsigned FAIL_LIMIT   = 25;

    localparam logic [7:0]  SETTLE_CAP   = 8'd200;
    localparam logic [7:0]  STREAK_CAP   = 8'd255;
    localparam logic [15:0] ADC_ALL_ONES = 16'hFFFF;

    // Register reset values
    localparam logic [15:0] DEAD_ZONE_RST = 16'd5500;
    localparam logic [14:0] NAV_THR_RST   = 15'd14000;
    localparam logic [15:0] REPEAT_MS_RST = 16'd200;
    localparam logic [15:0] HOLD_MS_RST   = 16'd450;
    localparam logic [15:0] CENTER_RST    = 16'd32768;

    localparam int unsigned PADDR_W = 5;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_INVERT_X       = 3'd0,
        REG_INVERT_Y       = 3'd1,
        REG_DEAD_ZONE      = 3'd2,
        REG_NAV_THRESHOLD  = 3'd3,
        REG_REPEAT_MS      = 3'd4,
        REG_HOLD_MS        = 3'd5,
        REG_CENTER_X_START = 3'd6,
        REG_CENTER_Y_START = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ACT_IDLE  = 3'd0,
        ACT_UP    = 3'd1,
        ACT_DOWN  = 3'd2,
        ACT_LEFT  = 3'd3,
        ACT_RIGHT = 3'd4,
        ACT_ENTER = 3'd5,
        ACT_BACK  = 3'd6
    } t_action;

    typedef struct packed {
        logic [15:0] adc_x;
        logic [15:0] adc_y;
        logic        button_down;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic        step_up;
        logic        step_down;
        logic        step_left;
        logic        step_right;
        logic        select_event;
        logic        escape_event;
        logic [2:0]  action;
        logic        led_lit;
        logic        sample_valid;
        logic        connected;
    } t_out_item;

    // Live configuration seen by the datapath
    typedef struct packed {
        logic        invert_x;
        logic        invert_y;
        logic [15:0] dead_zone;
        logic [14:0] nav_threshold;
        logic [15:0] repeat_ms;
        logic [15:0] hold_ms;
    } t_cfg;

    // Center reload on a write of a start register
    typedef struct packed {
        logic        load_x;
        logic        load_y;
        logic [15:0] value;
    } t_ctr_load;

    // Signed deflection of a reading from the center, optionally negated
    function automatic logic signed [16:0] f_deflect(input logic [15:0] adc,
                                                     input logic [15:0] ctr,
                                                     input logic        inv);
        logic signed [16:0] d;
        d = $signed({1'b0, adc}) - $signed({1'b0, ctr});
        return inv ? -d : d;
    endfunction

    // Magnitude of a deflection; always fits 16 bits
    function automatic logic [15:0] f_mag(input logic signed [16:0] d);
        logic signed [16:0] m;
        m = (d < 0) ? -d : d;
        return m[15:0];
    endfunction

endpackage

[rtl/core/jnq_cfg_regs.sv]
// jnq_cfg_regs: APB register file for the joystick qualifier settings.
// Depends on jnq_pkg (register map, t_cfg, t_ctr_load).
`timescale 1ns / 1ps

module jnq_cfg_regs
    import jnq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg,
    output t_ctr_load          o_ctr_load
);

    logic        r_invert_x;
    logic        r_invert_y;
    logic [15:0] r_dead_zone;
    logic [14:0] r_nav_threshold;
    logic [15:0] r_repeat_ms;
    logic [15:0] r_hold_ms;
    logic [15:0] r_center_x_start;
    logic [15:0] r_center_y_start;

    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[PADDR_W-1:2]);

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert_x       <= 1'b0;
            r_invert_y       <= 1'b0;
            r_dead_zone      <= DEAD_ZONE_RST;
            r_nav_threshold  <= NAV_THR_RST;
            r_repeat_ms      <= REPEAT_MS_RST;
            r_hold_ms        <= HOLD_MS_RST;
            r_center_x_start <= CENTER_RST;
            r_center_y_start <= CENTER_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_INVERT_X:       r_invert_x       <= pwdata[0];
                REG_INVERT_Y:       r_invert_y       <= pwdata[0];
                REG_DEAD_ZONE:      r_dead_zone      <= pwdata[15:0];
                REG_NAV_THRESHOLD:  r_nav_threshold  <= pwdata[14:0];
                REG_REPEAT_MS:      r_repeat_ms      <= pwdata[15:0];
                REG_HOLD_MS:        r_hold_ms        <= pwdata[15:0];
                REG_CENTER_X_START: r_center_x_start <= pwdata[15:0];
                REG_CENTER_Y_START: r_center_y_start <= pwdata[15:0];
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (idx)
            REG_INVERT_X:       prdata = {31'd0, r_invert_x};
            REG_INVERT_Y:       prdata = {31'd0, r_invert_y};
            REG_DEAD_ZONE:      prdata = {16'd0, r_dead_zone};
            REG_NAV_THRESHOLD:  prdata = {17'd0, r_nav_threshold};
            REG_REPEAT_MS:      prdata = {16'd0, r_repeat_ms};
            REG_HOLD_MS:        prdata = {16'd0, r_hold_ms};
            REG_CENTER_X_START: prdata = {16'd0, r_center_x_start};
            REG_CENTER_Y_START: prdata = {16'd0, r_center_y_start};
        endcase
    end

    assign o_cfg.invert_x      = r_invert_x;
    assign o_cfg.invert_y      = r_invert_y;
    assign o_cfg.dead_zone     = r_dead_zone;
    assign o_cfg.nav_threshold = r_nav_threshold;
    assign o_cfg.repeat_ms     = r_repeat_ms;
    assign o_cfg.hold_ms       = r_hold_ms;

    // A start write also recenters the matching axis
    assign o_ctr_load.load_x = wr_en && (idx == REG_CENTER_X_START);
    assign o_ctr_load.load_y = wr_en && (idx == REG_CENTER_Y_START);
    assign o_ctr_load.value  = pwdata[15:0];

endmodule

[rtl/core/jnq_nav_core.sv]
// jnq_nav_core: per-poll qualification datapath and its state (center,
// accumulators, timers, button, link health). Depends on jnq_pkg.
`timescale 1ns / 1ps

module jnq_nav_core
    import jnq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_ctr_load i_ctr_load,
    input  logic      i_fire,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [15:0]        r_center_x, r_center_y;
    logic signed [17:0] r_accum_x, r_accum_y;
    logic [7:0]         r_settle;
    logic [31:0]        r_last_step;
    logic [31:0]        r_press_time;
    logic               r_button_held;
    logic               r_long_fired;
    logic [7:0]         r_fail_streak;
    logic               r_present;

    logic [15:0]        n_center_x, n_center_y;
    logic signed [17:0] n_accum_x, n_accum_y;
    logic [7:0]         n_settle;
    logic [31:0]        n_last_step;
    logic [31:0]        n_press_time;
    logic               n_button_held;
    logic               n_long_fired;
    logic [7:0]         n_fail_streak;
    logic               n_present;

    logic               bad_read;
    logic signed [16:0] nx0, ny0, nx, ny;
    logic [15:0]        mag_x, mag_y;
    logic               near0, recenter, dead_x, dead_y;
    logic [7:0]         settle_inc;
    logic [19:0]        avg_x, avg_y;
    logic signed [18:0] base_x, base_y, sum_x, sum_y, clp_x, clp_y;
    logic signed [18:0] lim, thr;
    logic [31:0]        step_gap, hold_gap;
    logic               can_step;
    t_action            act;
    t_out_item          res;

    // Saturating symmetric clamp to +/- twice the threshold
    function automatic logic signed [18:0] f_clamp(input logic signed [18:0] v,
                                                   input logic signed [18:0] l);
        logic signed [18:0] r;
        r = v;
        if (r > l) r = l;
        if (r < -l) r = -l;
        return r;
    endfunction

    always_comb begin
        // Defaults: hold state
        n_center_x    = r_center_x;
        n_center_y    = r_center_y;
        n_accum_x     = r_accum_x;
        n_accum_y     = r_accum_y;
        n_settle      = r_settle;
        n_last_step   = r_last_step;
        n_press_time  = r_press_time;
        n_button_held = r_button_held;
        n_long_fired  = r_long_fired;
        n_fail_streak = r_fail_streak;
        n_present     = r_present;
        res           = '0;
        act           = ACT_IDLE;

        bad_read = ((i_item.adc_x == 16'd0) && (i_item.adc_y == 16'd0)) ||
                   ((i_item.adc_x == ADC_ALL_ONES) && (i_item.adc_y == ADC_ALL_ONES));

        // Settle check against the current center; only a valid poll tracks it
        nx0   = f_deflect(i_item.adc_x, r_center_x, i_cfg.invert_x);
        ny0   = f_deflect(i_item.adc_y, r_center_y, i_cfg.invert_y);
        near0 = (f_mag(nx0) < i_cfg.dead_zone) && (f_mag(ny0) < i_cfg.dead_zone);
        settle_inc = (r_settle < SETTLE_CAP) ? r_settle + 8'd1 : r_settle;
        recenter   = r_present && !bad_read && near0 &&
                     (settle_inc >= 8'(SETTLE_POLLS));

        // 15/16 center tracking
        avg_x = {r_center_x, 4'd0} - {4'd0, r_center_x} + {4'd0, i_item.adc_x};
        avg_y = {r_center_y, 4'd0} - {4'd0, r_center_y} + {4'd0, i_item.adc_y};
        if (recenter) begin
            n_center_x = avg_x[19:4];
            n_center_y = avg_y[19:4];
        end

        // Deflection against the updated center
        nx     = f_deflect(i_item.adc_x, n_center_x, i_cfg.invert_x);
        ny     = f_deflect(i_item.adc_y, n_center_y, i_cfg.invert_y);
        mag_x  = f_mag(nx);
        mag_y  = f_mag(ny);
        dead_x = mag_x < i_cfg.dead_zone;
        dead_y = mag_y < i_cfg.dead_zone;

        // Accumulate out-of-dead-zone deflection
        thr    = $signed({4'd0, i_cfg.nav_threshold});
        lim    = $signed({3'd0, i_cfg.nav_threshold, 1'b0});
        base_x = recenter ? 19'sd0 : 19'(r_accum_x);
        base_y = recenter ? 19'sd0 : 19'(r_accum_y);
        sum_x  = base_x + (dead_x ? 19'sd0 : 19'(nx));
        sum_y  = base_y + (dead_y ? 19'sd0 : 19'(ny));
        if (dead_x && dead_y) begin
            clp_x = '0;
            clp_y = '0;
        end else begin
            clp_x = f_clamp(sum_x, lim);
            clp_y = f_clamp(sum_y, lim);
        end

        step_gap = i_item.now_ms - r_last_step;
        hold_gap = i_item.now_ms - r_press_time;
        can_step = step_gap >= {16'd0, i_cfg.repeat_ms};

        if (!r_present) begin
            // Disconnected: ignore the poll
            res.led_lit = r_button_held;
        end else if (bad_read) begin
            n_accum_x     = '0;
            n_accum_y     = '0;
            n_fail_streak = (r_fail_streak < STREAK_CAP) ? r_fail_streak + 8'd1
                                                         : r_fail_streak;
            if (n_fail_streak > 8'(FAIL_LIMIT)) n_present = 1'b0;
            res.led_lit   = r_button_held;
            res.connected = n_present;
        end else begin
            n_fail_streak = '0;
            n_settle      = near0 ? settle_inc : 8'd0;

            // Emit steps, vertical first, horizontal wins the action code
            if (can_step) begin
                if (clp_y <= -thr) begin
                    res.step_up = 1'b1;
                    clp_y       = clp_y + thr;
                    n_last_step = i_item.now_ms;
                    act         = ACT_UP;
                end else if (clp_y >= thr) begin
                    res.step_down = 1'b1;
                    clp_y         = clp_y - thr;
                    n_last_step   = i_item.now_ms;
                    act           = ACT_DOWN;
                end
                if (clp_x <= -thr) begin
                    res.step_left = 1'b1;
                    clp_x         = clp_x + thr;
                    n_last_step   = i_item.now_ms;
                    act           = ACT_LEFT;
                end else if (clp_x >= thr) begin
                    res.step_right = 1'b1;
                    clp_x          = clp_x - thr;
                    n_last_step    = i_item.now_ms;
                    act            = ACT_RIGHT;
                end
            end else if (!dead_x || !dead_y) begin
                // Show the dominant direction while waiting out the interval
                if (mag_y >= mag_x) act = (ny < 0) ? ACT_UP : ACT_DOWN;
                else                act = (nx < 0) ? ACT_LEFT : ACT_RIGHT;
            end
            n_accum_x = clp_x[17:0];
            n_accum_y = clp_y[17:0];

            // Button: press, long hold, release
            if (i_item.button_down) begin
                if (!r_button_held) begin
                    n_button_held = 1'b1;
                    n_press_time  = i_item.now_ms;
                    n_long_fired  = 1'b0;
                end else if (!r_long_fired && (hold_gap >= {16'd0, i_cfg.hold_ms})) begin
                    res.escape_event = 1'b1;
                    n_long_fired     = 1'b1;
                    act              = ACT_BACK;
                end else if (r_long_fired) begin
                    act = ACT_BACK;
                end else begin
                    act = ACT_ENTER;
                end
            end else if (r_button_held) begin
                n_button_held = 1'b0;
                if (!r_long_fired) begin
                    res.select_event = 1'b1;
                    act              = ACT_ENTER;
                end
            end

            res.led_lit      = n_button_held;
            res.sample_valid = 1'b1;
            res.connected    = 1'b1;
        end
        res.action = act;
    end

    assign o_result = res;

    // Commit state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= CENTER_RST;
            r_center_y    <= CENTER_RST;
            r_accum_x     <= '0;
            r_accum_y     <= '0;
            r_settle      <= '0;
            r_last_step   <= '0;
            r_press_time  <= '0;
            r_button_held <= 1'b0;
            r_long_fired  <= 1'b0;
            r_fail_streak <= '0;
            r_present     <= 1'b1;
        end else begin
            if (i_fire) begin
                r_center_x    <= n_center_x;
                r_center_y    <= n_center_y;
                r_accum_x     <= n_accum_x;
                r_accum_y     <= n_accum_y;
                r_settle      <= n_settle;
                r_last_step   <= n_last_step;
                r_press_time  <= n_press_time;
                r_button_held <= n_button_held;
                r_long_fired  <= n_long_fired;
                r_fail_streak <= n_fail_streak;
                r_present     <= n_present;
            end
            if (i_ctr_load.load_x) r_center_x <= i_ctr_load.value;
            if (i_ctr_load.load_y) r_center_y <= i_ctr_load.value;
        end
    end

endmodule

[rtl/core/joystick_nav_qualifier.sv]
// joystick_nav_qualifier: top level with input and result registers around
// the qualification datapath. Depends on jnq_pkg, jnq_cfg_regs, jnq_nav_core.
`timescale 1ns / 1ps

// Takes one poll (two stick readings, button level, millisecond time) per
// clock while the result side does not stall, and returns exactly one result
// item per poll: the poll waits in the input register while the datapath
// works on it, and the result register holds the outcome. Stick state (center,
// step accumulators, timers, button and link health) is committed in the same
// edge that loads the result register, so the following poll already sees
// it and polls can stream at one per cycle while the result side does not
// stall. Write settings over the APB port only while no poll is in flight;
// writing a center start register also recenters that axis at once.
module joystick_nav_qualifier
    import jnq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg      cfg;
    t_ctr_load ctr_load;
    t_out_item result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free, in_free, advance;

    jnq_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (cfg),
        .o_ctr_load (ctr_load)
    );

    jnq_nav_core u_nav_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_ctr_load (ctr_load),
        .i_fire     (advance),
        .i_item     (r_in_item),
        .o_result   (result)
    );

    // Flow control: advance when the result register is empty or draining
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign in_free    = !r_in_valid || advance;
    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free)  r_in_valid  <= i_in_valid;
            if (out_free) r_out_valid <= r_in_valid;
        end
    end

    // Load payloads
    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) r_in_item  <= i_in_item;
        if (advance)               r_out_item <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Opposite steps on one axis never come out together
    a_axis_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.step_up && o_out_item.step_down) &&
                        !(o_out_item.step_left && o_out_item.step_right))
        else $error("opposite steps in one item");

    // Select and escape are exclusive
    a_button_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.select_event && o_out_item.escape_event))
        else $error("select and escape in one item");

    // Escape fires only while the button is held
    a_escape_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.escape_event |-> o_out_item.led_lit)
        else $error("escape without held button");

    // A disconnected stick never reports a valid sample
    a_disc_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.connected |-> !o_out_item.sample_valid &&
            (o_out_item.action == ACT_IDLE))
        else $error("valid sample while disconnected");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench for joystick_nav_qualifier. It streams polls, writes
// settings over APB between phases, and predicts every result item in a scoreboard class.
// Depends on jnq_pkg and the joystick_nav_qualifier RTL.

import jnq_pkg::*;

// Tracks the stick the way the block should and holds the result items still due
class nav_result_board;
    // live settings
    logic        inv_x, inv_y;
    logic [15:0] dz;
    logic [14:0] thr;
    logic [15:0] rep_ms, hold;
    // stick state
    logic [15:0] cx, cy;
    int          acc_x, acc_y;
    int unsigned settle;
    logic [31:0] last_step, press_at;
    logic        held, long_done, alive;
    int unsigned streak;
    t_out_item   due_reports[$];
    int          errors;
    int          checked;

    function new();
        inv_x     = 1'b0;
        inv_y     = 1'b0;
        dz        = DEAD_ZONE_RST;
        thr       = NAV_THR_RST;
        rep_ms    = REPEAT_MS_RST;
        hold      = HOLD_MS_RST;
        cx        = CENTER_RST;
        cy        = CENTER_RST;
        acc_x     = 0;
        acc_y     = 0;
        settle    = 0;
        last_step = '0;
        press_at  = '0;
        held      = 1'b0;
        long_done = 1'b0;
        alive     = 1'b1;
        streak    = 0;
        errors    = 0;
        checked   = 0;
    endfunction

    // Apply a register write; a center start write recenters that axis
    function void write_reg(t_reg_idx idx, logic [31:0] v);
        case (idx)
            REG_INVERT_X:       inv_x  = v[0];
            REG_INVERT_Y:       inv_y  = v[0];
            REG_DEAD_ZONE:      dz     = v[15:0];
            REG_NAV_THRESHOLD:  thr    = v[14:0];
            REG_REPEAT_MS:      rep_ms = v[15:0];
            REG_HOLD_MS:        hold   = v[15:0];
            REG_CENTER_X_START: cx     = v[15:0];
            REG_CENTER_Y_START: cy     = v[15:0];
            default: ;
        endcase
    endfunction

    function int offset(logic [15:0] adc, logic [15:0] ctr, logic inv);
        int d;
        d = int'(adc) - int'(ctr);
        return inv ? -d : d;
    endfunction

    function int magn(int v);
        return (v < 0) ? -v : v;
    endfunction

    function int clamp2(int v);
        int lim;
        lim = 2 * int'(thr);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    // Advance the stick state by one accepted poll and queue the result it causes
    function void take_poll(t_in_item p);
        t_out_item   r;
        t_action     act;
        int          nx, ny, th, dzi;
        logic [31:0] since;
        logic        cen_x, cen_y;
        r   = '0;
        act = ACT_IDLE;
        th  = int'(thr);
        dzi = int'(dz);
        if (alive) begin
            if ((p.adc_x == 16'h0 && p.adc_y == 16'h0) ||
                (p.adc_x == ADC_ALL_ONES && p.adc_y == ADC_ALL_ONES)) begin
                // bad reading: drop the accumulators, count toward a lost link
                acc_x = 0;
                acc_y = 0;
                if (streak < 255) streak++;
                if (streak > FAIL_LIMIT) alive = 1'b0;
            end else begin
                r.sample_valid = 1'b1;
                streak = 0;
                nx = offset(p.adc_x, cx, inv_x);
                ny = offset(p.adc_y, cy, inv_y);
                // track the center while the stick rests
                if (magn(nx) >= dzi || magn(ny) >= dzi) begin
                    settle = 0;
                end else begin
                    if (settle < 200) settle++;
                    if (settle >= SETTLE_POLLS) begin
                        cx    = 16'((int'(cx) * 15 + int'(p.adc_x)) / 16);
                        cy    = 16'((int'(cy) * 15 + int'(p.adc_y)) / 16);
                        acc_x = 0;
                        acc_y = 0;
                    end
                end
                nx    = offset(p.adc_x, cx, inv_x);
                ny    = offset(p.adc_y, cy, inv_y);
                cen_x = magn(nx) < dzi;
                cen_y = magn(ny) < dzi;
                if (cen_x && cen_y) begin
                    acc_x = 0;
                    acc_y = 0;
                end else begin
                    if (!cen_x) acc_x += nx;
                    if (!cen_y) acc_y += ny;
                    acc_x = clamp2(acc_x);
                    acc_y = clamp2(acc_y);
                end
                // emit steps once the repeat interval has passed
                since = p.now_ms - last_step;
                if (since >= {16'h0, rep_ms}) begin
                    if (acc_y <= -th) begin
                        r.step_up = 1'b1;
                        acc_y += th;
                        last_step = p.now_ms;
                        act = ACT_UP;
                    end else if (acc_y >= th) begin
                        r.step_down = 1'b1;
                        acc_y -= th;
                        last_step = p.now_ms;
                        act = ACT_DOWN;
                    end
                    if (acc_x <= -th) begin
                        r.step_left = 1'b1;
                        acc_x += th;
                        last_step = p.now_ms;
                        act = ACT_LEFT;
                    end else if (acc_x >= th) begin
                        r.step_right = 1'b1;
                        acc_x -= th;
                        last_step = p.now_ms;
                        act = ACT_RIGHT;
                    end
                end else if (!cen_x || !cen_y) begin
                    if (magn(ny) >= magn(nx)) act = (ny < 0) ? ACT_UP : ACT_DOWN;
                    else act = (nx < 0) ? ACT_LEFT : ACT_RIGHT;
                end
                // button: select on short release, escape once on a long hold
                since = p.now_ms - press_at;
                if (p.button_down) begin
                    if (!held) begin
                        held      = 1'b1;
                        press_at  = p.now_ms;
                        long_done = 1'b0;
                    end else if (!long_done && since >= {16'h0, hold}) begin
                        r.escape_event = 1'b1;
                        long_done = 1'b1;
                        act = ACT_BACK;
                    end else if (long_done) begin
                        act = ACT_BACK;
                    end else begin
                        act = ACT_ENTER;
                    end
                end else if (held) begin
                    held = 1'b0;
                    if (!long_done) begin
                        r.select_event = 1'b1;
                        act = ACT_ENTER;
                    end
                end
            end
        end
        r.action    = act;
        r.led_lit   = held;
        r.connected = alive;
        due_reports.push_back(r);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // Compare an accepted result item with the oldest one due
    function void check_report(t_out_item got);
        t_out_item want;
        if (due_reports.size() == 0) begin
            $error("result item with no poll waiting: %h", got);
            errors++;
            return;
        end
        want = due_reports.pop_front();
        checked++;
        cmp("step_up", want.step_up, got.step_up);
        cmp("step_down", want.step_down, got.step_down);
        cmp("step_left", want.step_left, got.step_left);
        cmp("step_right", want.step_right, got.step_right);
        cmp("select_event", want.select_event, got.select_event);
        cmp("escape_event", want.escape_event, got.escape_event);
        cmp("action", want.action, got.action);
        cmp("led_lit", want.led_lit, got.led_lit);
        cmp("sample_valid", want.sample_valid, got.sample_valid);
        cmp("connected", want.connected, got.connected);
    endfunction
endclass

module tb_top;

    localparam int LIMIT = 200000;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               poll_valid = 1'b0;
    logic               poll_stall;
    t_in_item           poll_item  = '0;
    logic               rep_valid;
    logic               rep_stall  = 1'b0;
    t_out_item          rep_item;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [31:0]        pwdata     = '0;
    logic [31:0]        prdata;
    logic               pready;

    nav_result_board    sb = new();
    logic [31:0]        clock_ms   = '0;
    int                 sent       = 0;
    int                 cycles     = 0;
    bit                 quiet      = 1'b0;
    bit                 cut_link   = 1'b0;

    joystick_nav_qualifier dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (poll_valid),
        .o_in_stall  (poll_stall),
        .i_in_item   (poll_item),
        .o_out_valid (rep_valid),
        .i_out_stall (rep_stall),
        .o_out_item  (rep_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Check every accepted result item
    always @(posedge clk) begin
        if (rst_n && rep_valid && !rep_stall) sb.check_report(rep_item);
    end

    // Result side: random stall bursts, calm stretches, and one long hold-off
    initial begin
        int k, burst;
        bit held_off;
        held_off = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held_off && sb.checked >= 700) begin
                held_off = 1'b1;
                rep_stall <= 1'b1;
                for (k = 0; k < 80; k++) @(posedge clk);
                rep_stall <= 1'b0;
                @(posedge clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 5);
                rep_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                rep_stall <= 1'b0;
                @(posedge clk);
            end else if ($urandom_range(0, 15) == 0) begin
                burst = $urandom_range(20, 60);
                rep_stall <= 1'b0;
                repeat (burst) @(posedge clk);
            end else begin
                rep_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    function automatic logic [15:0] clip16(int v);
        if (v < 0) return 16'h0;
        if (v > 65535) return ADC_ALL_ONES;
        return v[15:0];
    endfunction

    // Offer one item, maybe after a short gap, and note it once accepted
    task automatic send_poll(input t_in_item it);
        int gap;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 5);
            poll_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_valid <= 1'b1;
        poll_item  <= it;
        @(posedge clk);
        while (poll_stall) @(posedge clk);
        sb.take_poll(it);
    endtask

    task automatic poll(input logic [15:0] ax, input logic [15:0] ay, input logic btn,
                        input logic [31:0] t);
        t_in_item it;
        // keep the link up until the closing sequence
        if (!cut_link && sb.streak >= FAIL_LIMIT &&
            ((ax == 16'h0 && ay == 16'h0) || (ax == ADC_ALL_ONES && ay == ADC_ALL_ONES)))
            ax = ax ^ 16'h0001;
        it.adc_x       = ax;
        it.adc_y       = ay;
        it.button_down = btn;
        it.now_ms      = t;
        send_poll(it);
        sent++;
    endtask

    // One APB write: setup cycle, then access cycle; caller drops psel afterwards
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // A run of polls shaped like real use: rest, push, sweep, noise or dropouts
    task automatic run_gesture();
        int kind, n, dt, hit, hold_len, half, ox, oy, k;
        logic [15:0] ax, ay;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(3, 40);
        dt   = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 40);
        hit  = $urandom_range(0, n - 1);
        case ($urandom_range(0, 3))
            0:       hold_len = 0;
            1:       hold_len = $urandom_range(1, 3);
            default: hold_len = $urandom_range(1, n);
        endcase
        if (kind == 9) begin
            hold_len = n - hit;
            dt       = $urandom_range(10, 60);
        end
        half = int'(sb.dz) / 2;
        ox   = int'($urandom_range(0, 32767));
        oy   = int'($urandom_range(0, 32767));
        if ($urandom_range(0, 1)) ox = -ox;
        if ($urandom_range(0, 1)) oy = -oy;
        // straight pushes keep the other axis near center
        if (kind >= 3 && kind <= 5) begin
            if ($urandom_range(0, 1)) ox = ox / 16;
            else oy = oy / 16;
        end
        if (kind == 8) n = $urandom_range(1, 25);
        for (k = 0; k < n; k++) begin
            case (kind)
                0, 1, 2, 9: begin
                    ax = clip16(int'(sb.cx) + int'($urandom_range(0, 2 * half)) - half);
                    ay = clip16(int'(sb.cy) + int'($urandom_range(0, 2 * half)) - half);
                end
                7: begin
                    ax = 16'($urandom);
                    ay = 16'($urandom);
                end
                8: begin
                    ax = $urandom_range(0, 1) ? ADC_ALL_ONES : 16'h0;
                    ay = ax;
                end
                default: begin
                    ax = clip16(int'(sb.cx) + ox + int'($urandom_range(0, 400)) - 200);
                    ay = clip16(int'(sb.cy) + oy + int'($urandom_range(0, 400)) - 200);
                end
            endcase
            // advance time, with rare long pauses and jumps anywhere
            case ($urandom_range(0, 149))
                0:       clock_ms = $urandom;
                1, 2:    clock_ms += $urandom_range(1000, 70000);
                default: clock_ms += dt + $urandom_range(0, 5);
            endcase
            poll(ax, ay, (k >= hit && k < hit + hold_len), clock_ms);
        end
    endtask

    initial begin
        logic [31:0] cfg [8];
        int ph, k, n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed polls at reset settings
        poll(16'h0000, 16'h0000, 1'b0, 32'd1000);       // both readings zero
        poll(16'hFFFF, 16'hFFFF, 1'b0, 32'd1001);       // both readings all ones
        poll(16'h0000, 16'hFFFF, 1'b1, 32'd1300);       // full left and down, press
        poll(16'hFFFF, 16'h0000, 1'b1, 32'd1310);       // full right and up, still held
        poll(16'h8000, 16'h8000, 1'b1, 32'd1800);       // hold time reached
        poll(16'h8000, 16'h8000, 1'b1, 32'd1820);
        poll(16'h8000, 16'h8000, 1'b0, 32'd1830);       // release after long hold
        poll(16'h8000, 16'h8000, 1'b1, 32'd1840);
        poll(16'h8000, 16'h8000, 1'b0, 32'd1850);       // short press released
        poll(16'h8000, 16'h2000, 1'b0, 32'd2100);
        poll(16'h8000, 16'h2000, 1'b0, 32'd2150);       // inside the repeat interval
        poll(16'h8000, 16'hE000, 1'b0, 32'd2400);
        poll(16'h2000, 16'h8000, 1'b0, 32'd2700);
        poll(16'hE000, 16'h8000, 1'b0, 32'd3000);
        poll(16'h0000, 16'h8000, 1'b0, 32'd3300);       // one axis at zero stays valid
        poll(16'hFFFF, 16'h0001, 1'b0, 32'd3600);
        poll(16'h9000, 16'h8000, 1'b0, 32'hFFFF_FFF0);  // just before the time wraps
        poll(16'hF000, 16'h8000, 1'b0, 32'h0000_0040);  // just after
        poll_valid <= 1'b0;
        clock_ms = 32'hFFFF_F800;

        for (ph = 1; ph <= 7; ph++) begin
            while (sb.due_reports.size() != 0) @(posedge clk);
            case (ph)
                1: cfg = '{32'd1, 32'd0, 32'd3000, 32'd8000, 32'd100, 32'd300,
                           32'd30000, 32'd35000};
                2: cfg = '{32'd0, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd65535};
                3: cfg = '{32'd1, 32'd1, 32'd65535, 32'd32767, 32'd65535, 32'd65535,
                           32'd65535, 32'd0};
                4: cfg = '{32'd0, 32'd0, 32'd1000, 32'd0, 32'd50, 32'd100,
                           32'd32768, 32'd32768};  // zero threshold
                5: cfg = '{$urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 12000), $urandom_range(1, 32767),
                           $urandom_range(0, 400), $urandom_range(0, 900),
                           $urandom_range(20000, 45000), $urandom_range(20000, 45000)};
                6: cfg = '{$urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 65535), $urandom_range(1, 32767),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535)};
                default: cfg = '{32'd0, 32'd0, 32'd5500, 32'd14000, 32'd200, 32'd450,
                                 32'd32768, 32'd32768};
            endcase
            for (k = 0; k < 8; k++) apb_write(t_reg_idx'(k), cfg[k]);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            quiet = (ph == 7);
            while (sent < ph * 275) run_gesture();
            if (ph == 7) begin
                // the longest tolerated run of bad readings, then one good poll
                for (k = 0; k < FAIL_LIMIT; k++) begin
                    clock_ms += 10;
                    poll(16'h0000, 16'h0000, 1'b1, clock_ms);
                end
                clock_ms += 10;
                poll(sb.cx, sb.cy, 1'b1, clock_ms);
                // now lose the link with the button held; later polls are ignored
                cut_link = 1'b1;
                n = $urandom_range(26, 30);
                for (k = 0; k < n; k++) begin
                    clock_ms += 10;
                    poll(ADC_ALL_ONES, ADC_ALL_ONES, 1'b0, clock_ms);
                end
                for (k = 0; k < 10; k++) begin
                    clock_ms += 10;
                    poll(16'($urandom), 16'($urandom), $urandom_range(0, 1), clock_ms);
                end
            end
            poll_valid <= 1'b0;
        end

        while (sb.due_reports.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/jnq_pkg.sv
rtl/core/jnq_cfg_regs.sv
rtl/core/jnq_nav_core.sv
rtl/core/joystick_nav_qualifier.sv
tb/tb_top.sv
